// ===== rtl/core/lcgs_pkg.sv =====
// Shared types and constants for the shuffled minimal-standard generator.
package lcgs_pkg;

  localparam int unsigned VAL_W        = 31;
  localparam int unsigned MULT_W       = 15;
  localparam int unsigned PROD_W       = VAL_W + MULT_W;
  localparam int unsigned WARMUP_EXTRA = 8;

  localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
  localparam logic [VAL_W-1:0]  LCG_MOD  = 31'h7FFF_FFFF;

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [VAL_W-1:0] seed;
  } lcgs_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] deviate;
    logic [VAL_W-1:0] generator_state;
  } lcgs_out_t;

endpackage

// ===== rtl/core/lcgs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lcgs_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/lcgs_mulmod.sv =====
// Unit computing 16807 * x modulo 2^31 - 1 by a Mersenne fold, registering the product before the fold.
module lcgs_mulmod
  import lcgs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAL_W-1:0] x_i,
  output logic             busy_o,
  output logic [VAL_W-1:0] y_o
);

  logic              busy_q;
  logic [PROD_W-1:0] prod_q;
  logic [VAL_W-1:0]  y_q;
  logic [VAL_W:0]    fold_sum;
  logic [VAL_W:0]    fold_dif;

  assign fold_sum = (VAL_W+1)'(prod_q[PROD_W-1:VAL_W]) + (VAL_W+1)'(prod_q[VAL_W-1:0]);
  assign fold_dif = fold_sum - (VAL_W+1)'(LCG_MOD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PROD_W'(LCG_MULT) * PROD_W'(x_i);
    end else if (busy_q) begin
      if (fold_sum >= (VAL_W+1)'(LCG_MOD)) begin
        y_q <= fold_dif[VAL_W-1:0];
      end else begin
        y_q <= fold_sum[VAL_W-1:0];
      end
    end
  end

  assign busy_o = busy_q;
  assign y_o    = y_q;

endmodule

// ===== rtl/core/lcgs_idx_div.sv =====
// Reciprocal multiply that maps the saved output to a shuffle table slot.
module lcgs_idx_div
  import lcgs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [VAL_W-1:0]               dividend_i,
  output logic                           busy_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] index_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned Q_W   = IDX_W + 1;
  localparam int unsigned PW    = 64;
  localparam longint unsigned DIVISOR = 64'd1 + 64'd2147483646 / TABLE_DEPTH;
  localparam int unsigned SHIFT = VAL_W + $clog2(DIVISOR);
  localparam longint unsigned RECIP_FULL = ((64'd1 << SHIFT) + DIVISOR - 64'd1) / DIVISOR;
  localparam logic [31:0]      RECIP = 32'(RECIP_FULL);
  localparam logic [Q_W-1:0]   LAST  = Q_W'(TABLE_DEPTH - 1);

  logic          busy_q;
  logic [PW-1:0] prod_q;
  logic [Q_W-1:0] quot;

  assign quot = prod_q[SHIFT +: Q_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PW'(dividend_i) * PW'(RECIP);
    end
  end

  assign busy_o  = busy_q;
  assign index_o = (quot > LAST) ? LAST[IDX_W-1:0] : quot[IDX_W-1:0];

endmodule

// ===== rtl/core/lcg_shuffle_random_generator.sv =====
// Top level: minimal-standard generator with a shuffle table, under a small sequencer.
// A draw runs the multiply-fold unit, with the slot index ready alongside, then the
// registered table read, and registers the result at the output.
// A reseed, or a draw while the saved output is zero, first runs TABLE_DEPTH + 8 steps
// of the multiply-fold unit. One item is in work at a time; the next is taken the
// cycle after the result is registered.
// Reset sets the generator to 1 and the saved output to 0; the table is not cleared.
module lcg_shuffle_random_generator
  import lcgs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lcgs_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lcgs_out_t out_data_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned STEPS  = TABLE_DEPTH + WARMUP_EXTRA;
  localparam int unsigned CNT_W  = $clog2(STEPS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WARM,
    S_DRAW,
    S_READ
  } state_e;

  state_e           state_q, state_d;
  logic [VAL_W-1:0] lcg_q, lcg_d;
  logic [VAL_W-1:0] saved_q, saved_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  lcgs_out_t        out_data_q, out_data_d;

  logic             mul_start, mul_busy;
  logic [VAL_W-1:0] mul_y;
  logic             div_start, div_busy;
  logic [IDX_W-1:0] div_idx;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;
  logic [VAL_W-1:0] seed_fix;
  logic [CNT_W-1:0] slot;

  assign seed_fix = (in_data_i.seed == '0 || in_data_i.seed == LCG_MOD) ?
                    VAL_W'(1) : in_data_i.seed;
  assign slot     = cnt_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    lcg_d       = lcg_q;
    saved_d     = saved_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = lcg_q;
    ram_re      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mul_start = 1'b1;
          if (in_data_i.cmd == CMD_RESEED || saved_q == '0) begin
            lcg_d   = seed_fix;
            cnt_d   = CNT_W'(STEPS);
            state_d = S_WARM;
          end else begin
            div_start = 1'b1;
            state_d   = S_DRAW;
          end
        end
      end
      S_WARM: begin
        if (!mul_busy) begin
          lcg_d     = mul_y;
          cnt_d     = cnt_q - 1'b1;
          mul_start = 1'b1;
          if (cnt_q <= CNT_W'(TABLE_DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = slot[IDX_W-1:0];
            ram_wdata = mul_y;
          end
          if (cnt_q == CNT_W'(1)) begin
            saved_d   = mul_y;
            div_start = 1'b1;
            state_d   = S_DRAW;
          end
        end
      end
      S_DRAW: begin
        if (!mul_busy && !div_busy) begin
          lcg_d   = mul_y;
          idx_d   = div_idx;
          ram_re  = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (!out_valid_q || out_ready_i) begin
          ram_we                     = 1'b1;
          saved_d                    = ram_rdata;
          out_valid_d                = 1'b1;
          out_data_d.deviate         = ram_rdata;
          out_data_d.generator_state = lcg_q;
          state_d                    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lcg_q       <= VAL_W'(1);
      saved_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      lcg_q       <= lcg_d;
      saved_q     <= saved_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  lcgs_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (lcg_d),
    .busy_o  (mul_busy),
    .y_o     (mul_y)
  );

  lcgs_idx_div #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_idx_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (saved_d),
    .busy_o     (div_busy),
    .index_o    (div_idx)
  );

  lcgs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (div_idx),
    .rd_data_o (ram_rdata)
  );

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/lcgs_checker.sv =====
// Port-level checker for the shuffled generator, bound to the top level.
module lcgs_checker
  import lcgs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input lcgs_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input lcgs_out_t out_data_o
);

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // The block works on one beat at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.deviate != '0 && out_data_o.deviate != LCG_MOD)
    else $error("deviate out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.generator_state != '0 &&
                    out_data_o.generator_state != LCG_MOD)
    else $error("generator state out of range");

endmodule

bind lcg_shuffle_random_generator lcgs_checker u_lcgs_checker (.*);
